// ===== hdl/time_table_interp_weights_macros.svh =====
// Assertion macros shared by the time table interpolation block.
// Included by the modules that carry checks; no other dependencies.
`ifndef TIME_TABLE_INTERP_WEIGHTS_MACROS_SVH
`define TIME_TABLE_INTERP_WEIGHTS_MACROS_SVH
`ifndef SYNTHESIS
`define TTIW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ttiw check failed");
`define TTIW_ASSERT_NEXT(lbl, cause, effect) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) cause |=> effect) \
        else $error("ttiw sequence check failed");
`else
`define TTIW_ASSERT(lbl, prop)
`define TTIW_ASSERT_NEXT(lbl, cause, effect)
`endif
`endif

// ===== hdl/ttiw_pkg.sv =====
// Package for the time table interpolation block: widths, codes, types.
// No dependencies; used by every other file of the block but the macro header.
`timescale 1ns / 1ps

package ttiw_pkg;

    localparam int RECORD_DEPTH = 64;
    localparam int IDX_W        = $clog2(RECORD_DEPTH);
    localparam int CNT_W        = IDX_W + 1;
    localparam int TIME_W       = 63;
    localparam int BT_W         = 64;
    localparam int PER_W        = 62;
    localparam int WGT_W        = 17;
    localparam int FRAC_W       = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 63;
    localparam int FIFO_DEPTH   = 2;

    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic              is_query;
        logic [IDX_W-1:0]  idx;
        logic              restart;
        logic [BT_W-1:0]   t;
    } t_cmd;

    typedef struct packed {
        logic [PER_W-1:0]  period;
        logic [TIME_W-1:0] reference;
        logic [IDX_W-1:0]  last;
        logic              periodic;
    } t_cfg;

    typedef enum logic [1:0] {
        F_IDLE,
        F_ABS,
        F_DIV,
        F_FIX
    } t_front_state;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_LAST,
        BK_FIRST,
        BK_SCAN,
        BK_WALK,
        BK_LEFT,
        BK_DIV,
        BK_ITER,
        BK_DONE
    } t_back_state;

endpackage

// ===== hdl/ttiw_in_if.sv =====
// Input channel of the time table block: valid/ready plus the item fields.
// Depends on ttiw_pkg.
`timescale 1ns / 1ps

interface ttiw_in_if import ttiw_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [IDX_W-1:0]         record_index;
    logic signed [TIME_W-1:0] time_value;
    logic                     restart_walk;

    modport source (output valid, opcode, record_index, time_value, restart_walk,
                    input ready);
    modport sink   (input valid, opcode, record_index, time_value, restart_walk,
                    output ready);
endinterface

// ===== hdl/ttiw_out_if.sv =====
// Result channel of the time table block: valid/ready plus indices and weight.
// Depends on ttiw_pkg.
`timescale 1ns / 1ps

interface ttiw_out_if import ttiw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  left_index;
    logic [IDX_W-1:0]  right_index;
    logic [WGT_W-1:0]  weight;

    modport source (output valid, left_index, right_index, weight, input ready);
    modport sink   (input valid, left_index, right_index, weight, output ready);
endinterface

// ===== hdl/ttiw_front.sv =====
// Front end: accepts words, reduces query times modulo the period (bit-serial
// remainder, one bit a cycle) and hands commands to the queue. Uses ttiw_pkg.
`timescale 1ns / 1ps
`include "time_table_interp_weights_macros.svh"

module ttiw_front import ttiw_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    ttiw_in_if.sink      i_in,
    output logic         o_push,
    output t_cmd         o_word,
    input  logic         i_full
);

    t_front_state        r_state, n_state;
    t_cmd                r_word;
    logic                r_full;
    logic [BT_W-1:0]     r_d;
    logic                r_neg;
    logic [PER_W-1:0]    r_rem;
    logic [5:0]          r_cnt;

    logic                accept;
    logic [BT_W-1:0]     t_ext;
    logic [BT_W-1:0]     ref_ext;
    logic [PER_W:0]      cand;
    logic [PER_W-1:0]    rem_next;

    assign t_ext   = {i_in.time_value[TIME_W-1], i_in.time_value};
    assign ref_ext = {i_cfg.reference[TIME_W-1], i_cfg.reference};
    assign accept  = i_in.valid && i_in.ready;
    assign cand    = {r_rem, r_d[BT_W-1]};

    always_comb begin
        if (cand >= {1'b0, i_cfg.period}) begin
            rem_next = PER_W'(cand - {1'b0, i_cfg.period});
        end else begin
            rem_next = cand[PER_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept && i_in.opcode == OP_QUERY && i_cfg.periodic) begin
                    n_state = F_ABS;
                end
            end
            F_ABS: n_state = F_DIV;
            F_DIV: begin
                if (r_cnt == 6'd63) begin
                    n_state = F_FIX;
                end
            end
            F_FIX:   n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready = (r_state == F_IDLE) && !r_full;
        o_push     = r_full && !i_full;
        o_word     = r_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_push) begin
                r_full <= 1'b0;
            end
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_word.is_query <= i_in.opcode;
                        r_word.idx      <= i_in.record_index;
                        r_word.restart  <= i_in.restart_walk;
                        r_word.t        <= t_ext;
                        r_d             <= t_ext - ref_ext;
                        if (!(i_in.opcode == OP_QUERY && i_cfg.periodic)) begin
                            r_full <= 1'b1;
                        end
                    end
                end
                F_ABS: begin
                    r_neg <= r_d[BT_W-1];
                    if (r_d[BT_W-1]) begin
                        r_d <= BT_W'(0) - r_d;
                    end
                    r_rem <= '0;
                    r_cnt <= '0;
                end
                F_DIV: begin
                    r_rem <= rem_next;
                    r_d   <= {r_d[BT_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                end
                F_FIX: begin
                    // negative offsets fold back into 0..period-1
                    if (r_neg && r_rem != '0) begin
                        r_word.t <= {2'b00, i_cfg.period - r_rem};
                    end else begin
                        r_word.t <= {2'b00, r_rem};
                    end
                    r_full <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    `TTIW_ASSERT(a_rem_below_period, (r_state == F_DIV) |-> (r_rem < i_cfg.period))

endmodule

// ===== hdl/ttiw_fifo.sv =====
// Short command queue between the front end and the table walker.
// Uses ttiw_pkg for the command type and depth.
`timescale 1ns / 1ps
`include "time_table_interp_weights_macros.svh"

module ttiw_fifo import ttiw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_word,
    output logic  o_full,
    output logic  o_valid,
    output t_cmd  o_word,
    input  logic  i_pop
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int QCNT_W = $clog2(FIFO_DEPTH + 1);

    t_cmd              r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `TTIW_ASSERT(a_count_bound, r_count <= QCNT_W'(FIFO_DEPTH))

endmodule

// ===== hdl/ttiw_back.sv =====
// Back end: end-time memory, forward walk over the table and a bit-serial
// Q0.16 fraction unit; holds the result register. Uses ttiw_pkg.
`timescale 1ns / 1ps
`include "time_table_interp_weights_macros.svh"

module ttiw_back import ttiw_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_q_valid,
    input  t_cmd         i_q_word,
    output logic         o_q_pop,
    ttiw_out_if.source   o_out
);

    logic signed [BT_W-1:0] r_mem [RECORD_DEPTH];
    logic signed [BT_W-1:0] r_rdata;

    t_back_state            r_state, n_state;
    logic signed [BT_W-1:0] r_t, r_prev, r_rt, r_num, r_den;
    logic [BT_W-1:0]        r_rem;
    logic [FRAC_W-1:0]      r_q;
    logic [3:0]             r_cnt;
    logic [IDX_W-1:0]       r_walk, r_left, r_right;
    logic [WGT_W-1:0]       r_weight;
    logic                   r_ovalid;
    logic [IDX_W-1:0]       r_oleft, r_oright;
    logic [WGT_W-1:0]       r_oweight;

    logic                   mem_we;
    logic [IDX_W-1:0]       mem_raddr;
    logic                   out_load;
    logic signed [BT_W-1:0] limit;
    logic signed [BT_W-1:0] q_t;
    logic [IDX_W-1:0]       walk_eff;
    logic                   walk_more, scan_more;
    logic [BT_W:0]          twice;
    logic                   take;

    assign limit    = $signed({2'b00, i_cfg.period}) - 64'sd1;
    assign q_t      = $signed(i_q_word.t);
    assign walk_eff = (r_walk >= i_cfg.last) ? '0 : r_walk;
    assign walk_more = ({1'b0, r_walk} + CNT_W'(1) < {1'b0, i_cfg.last}) && (r_rdata < r_t);
    assign scan_more = (r_left < i_cfg.last) && (r_rdata < limit);
    assign twice    = {r_rem, 1'b0};
    assign take     = twice >= {1'b0, r_den};

    // end-time store, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_q_word.idx] <= $signed(i_q_word.t);
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid && i_q_word.is_query == OP_QUERY) begin
                    n_state = BK_LAST;
                end
            end
            BK_LAST: n_state = (r_t >= r_rdata) ? BK_DONE : BK_FIRST;
            BK_FIRST: begin
                if (r_t < r_rdata) begin
                    if (!i_cfg.periodic) begin
                        n_state = BK_DONE;
                    end else if ((i_cfg.last != '0) && (r_rdata < limit)) begin
                        n_state = BK_SCAN;
                    end else begin
                        n_state = BK_DIV;
                    end
                end else begin
                    n_state = BK_WALK;
                end
            end
            BK_SCAN: n_state = scan_more ? BK_SCAN : BK_DIV;
            BK_WALK: n_state = walk_more ? BK_WALK : BK_LEFT;
            BK_LEFT: n_state = BK_DIV;
            BK_DIV: begin
                if (r_num <= 0 || r_den <= 0 || $unsigned(r_num) >= $unsigned(r_den)) begin
                    n_state = BK_DONE;
                end else begin
                    n_state = BK_ITER;
                end
            end
            BK_ITER: n_state = (r_cnt == 4'd15) ? BK_DONE : BK_ITER;
            BK_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_pop   = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = '0;
        out_load  = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_q_pop   = i_q_valid;
                mem_we    = i_q_valid && (i_q_word.is_query == OP_LOAD);
                mem_raddr = i_cfg.last;
            end
            BK_FIRST: mem_raddr = (r_t < r_rdata) ? IDX_W'(1) : walk_eff + 1'b1;
            BK_SCAN:  mem_raddr = r_left + 1'b1;
            BK_WALK:  mem_raddr = walk_more ? r_walk + IDX_W'(2) : r_walk;
            BK_DONE:  out_load  = !r_ovalid || o_out.ready;
            default: begin
            end
        endcase
        o_out.valid       = r_ovalid;
        o_out.left_index  = r_oleft;
        o_out.right_index = r_oright;
        o_out.weight      = r_oweight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_walk   <= '0;
            r_prev   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                BK_IDLE: begin
                    if (i_q_valid && i_q_word.is_query == OP_QUERY) begin
                        if (i_q_word.restart || q_t < r_prev) begin
                            r_walk <= '0;
                        end
                        r_prev <= q_t;
                        r_t    <= q_t;
                    end
                end
                BK_LAST: begin
                    r_left   <= i_cfg.last;
                    r_right  <= i_cfg.last;
                    r_weight <= '0;
                end
                BK_FIRST: begin
                    if (r_t < r_rdata) begin
                        // before the first record; periodic mode wraps from the end
                        r_right  <= '0;
                        r_weight <= '0;
                        r_num    <= r_t;
                        r_den    <= r_rdata;
                        if (i_cfg.periodic && (i_cfg.last != '0) && (r_rdata < limit)) begin
                            r_left <= IDX_W'(1);
                        end else begin
                            r_left <= '0;
                        end
                    end else begin
                        r_walk <= walk_eff;
                    end
                end
                BK_SCAN: begin
                    if (scan_more) begin
                        r_left <= r_left + 1'b1;
                    end
                end
                BK_WALK: begin
                    if (walk_more) begin
                        r_walk <= r_walk + 1'b1;
                    end else begin
                        r_rt    <= r_rdata;
                        r_left  <= r_walk;
                        r_right <= r_walk + 1'b1;
                    end
                end
                BK_LEFT: begin
                    r_num <= r_t - r_rdata;
                    r_den <= r_rt - r_rdata;
                end
                BK_DIV: begin
                    if (r_num <= 0 || r_den <= 0) begin
                        r_weight <= '0;
                    end else if ($unsigned(r_num) >= $unsigned(r_den)) begin
                        r_weight <= WGT_ONE;
                    end
                    r_rem <= $unsigned(r_num);
                    r_q   <= '0;
                    r_cnt <= '0;
                end
                BK_ITER: begin
                    r_rem <= take ? BT_W'(twice - {1'b0, r_den}) : BT_W'(twice);
                    r_q   <= {r_q[FRAC_W-2:0], take};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_weight <= {1'b0, r_q[FRAC_W-2:0], take};
                    end
                end
                BK_DONE: begin
                    if (out_load) begin
                        r_oleft   <= r_left;
                        r_oright  <= r_right;
                        r_oweight <= r_weight;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `TTIW_ASSERT(a_weight_range, r_ovalid |-> (r_oweight <= WGT_ONE))
    `TTIW_ASSERT(a_walk_in_table, (r_state == BK_WALK) |-> (r_walk < i_cfg.last))
    `TTIW_ASSERT(a_rem_below_den, (r_state == BK_ITER) |-> (r_rem < $unsigned(r_den)))
    `TTIW_ASSERT_NEXT(a_done_loads, (r_state == BK_DONE) && (!r_ovalid || o_out.ready), r_ovalid)

endmodule

// ===== hdl/time_table_interp_weights.sv =====
// Top level of the time table interpolation block: configuration registers,
// front end, command queue and table walker. Uses ttiw_pkg and both interfaces.
//
// Input channel i_in carries load words (opcode 0: write record_index with an
// end time) and query words (opcode 1: requested time). Each query returns one
// word on o_out with left/right record indices and a Q1.16 weight; loads
// return nothing. Configuration (period, reference time, record count) must
// be written through i_cfg_we/i_cfg_idx/i_cfg_data only while the block is
// idle; the block itself does not enforce this. A query goes to the walker
// straight from the front end, or in periodic mode after the 64-step serial
// remainder. A clamped query (right of the table, or left of it when not
// periodic) is answered from the last or first end time; otherwise the
// walker reads the memory, advances the search pointer record by record (up
// to the record count) and runs a bit-serial division for the weight. The
// front accepts the next word while the walker works, through a two-deep
// queue. Reset clears the search pointer, the last requested time, the queue
// and the result valid flag; the end-time memory is not cleared and must be
// loaded before use. A stalled receiver holds the result register; the
// walker then waits and the queue fills behind it.
`timescale 1ns / 1ps

module time_table_interp_weights import ttiw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ttiw_in_if.sink               i_in,
    ttiw_out_if.source            o_out
);

    logic [PER_W-1:0]  r_period;
    logic [TIME_W-1:0] r_reference;
    logic [CNT_W-1:0]  r_count;
    t_cfg              cfg;

    logic push, full, q_valid, q_pop;
    t_cmd push_word, q_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= '0;
            r_reference <= '0;
            r_count     <= CNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PERIOD:    r_period    <= i_cfg_data[PER_W-1:0];
                CFG_REFERENCE: r_reference <= i_cfg_data[TIME_W-1:0];
                CFG_COUNT:     r_count     <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // record count clamps to 1..RECORD_DEPTH
    always_comb begin
        cfg.period    = r_period;
        cfg.reference = r_reference;
        cfg.periodic  = (r_period > PER_W'(1));
        if (r_count == '0) begin
            cfg.last = '0;
        end else if (r_count > CNT_W'(RECORD_DEPTH)) begin
            cfg.last = IDX_W'(RECORD_DEPTH - 1);
        end else begin
            cfg.last = IDX_W'(r_count - 1'b1);
        end
    end

    ttiw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_push  (push),
        .o_word  (push_word),
        .i_full  (full)
    );

    ttiw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .o_full  (full),
        .o_valid (q_valid),
        .o_word  (q_word),
        .i_pop   (q_pop)
    );

    ttiw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_word  (q_word),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

// ===== dv/time_table_interp_weights_test.sv =====
// Self-checking bench for time_table_interp_weights: loads end-time tables and
// queries them, comparing each result word with an in-bench interpolation model.
// Depends on ttiw_pkg, ttiw_in_if, ttiw_out_if and the block itself.
`timescale 1ns / 1ps

module time_table_interp_weights_test;
    import ttiw_pkg::*;

    typedef struct {
        logic                     is_query;
        logic [IDX_W-1:0]         idx;
        logic signed [TIME_W-1:0] tv;
        logic                     restart;
    } t_word;

    typedef struct {
        logic [IDX_W-1:0] left_idx;
        logic [IDX_W-1:0] right_idx;
        logic [WGT_W-1:0] wgt;
    } t_interp;

    localparam int WATCHDOG_LIMIT = 5000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ttiw_in_if  in_ch ();
    ttiw_out_if out_ch ();

    time_table_interp_weights i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // interpolation model state
    longint               end_times [RECORD_DEPTH];
    int unsigned          walk_ptr;
    longint               last_request;
    logic [PER_W-1:0]     m_period;
    logic signed [63:0]   m_reference;
    logic [CNT_W-1:0]     m_count;

    t_word   word_q [$];
    t_interp interp_q [$];

    int  n_errors;
    int  send_gap;
    int  recv_stall;
    int  hold_cnt;
    bit  hold_req;
    bit  quiet;
    bit  took;
    int  idle_cycles;

    // stimulus plan
    longint plan [RECORD_DEPTH];
    int     plan_n;
    longint plan_step;
    longint cursor;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic longint rnd_below(longint unsigned n);
        if (n == 0)
            return 0;
        return longint'(rnd64() % n);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 55)
            return 0;
        if (r < 96)
            return $urandom_range(3, 1);
        return $urandom_range(80, 20);
    endfunction

    function automatic logic [WGT_W-1:0] q16_fraction(longint num, longint den);
        logic [127:0] wide;
        if (num <= 0 || den <= 0)
            return '0;
        if (num >= den)
            return WGT_ONE;
        wide = (128'(num) << FRAC_W) / 128'(den);
        return wide[WGT_W-1:0];
    endfunction

    function automatic t_interp interpolate(t_word w);
        t_interp res;
        int unsigned cnt, last;
        longint t, p, d, r, lim;
        bit periodic;
        periodic = m_period > 1;
        cnt = m_count;
        if (cnt == 0)
            cnt = 1;
        if (cnt > RECORD_DEPTH)
            cnt = RECORD_DEPTH;
        last = cnt - 1;
        t = longint'(w.tv);
        if (periodic) begin
            p = longint'({2'b00, m_period});
            d = t - m_reference;
            r = d % p;
            if (r < 0)
                r += p;
            t = r;
        end
        if (w.restart || t < last_request)
            walk_ptr = 0;
        last_request = t;
        res.wgt = '0;
        if (t >= end_times[last]) begin
            res.left_idx  = IDX_W'(last);
            res.right_idx = IDX_W'(last);
        end else if (t < end_times[0]) begin
            res.left_idx  = '0;
            res.right_idx = '0;
            if (periodic) begin
                lim = p - 1;
                while (res.left_idx < last && end_times[res.left_idx] < lim)
                    res.left_idx++;
                if (end_times[0] > 1)
                    res.wgt = q16_fraction(t, end_times[0]);
            end
        end else begin
            if (walk_ptr >= last)
                walk_ptr = 0;
            while (walk_ptr + 1 < last && end_times[walk_ptr + 1] < t)
                walk_ptr++;
            res.left_idx  = IDX_W'(walk_ptr);
            res.right_idx = IDX_W'(walk_ptr + 1);
            res.wgt = q16_fraction(t - end_times[walk_ptr],
                                   end_times[walk_ptr + 1] - end_times[walk_ptr]);
        end
        return res;
    endfunction

    // accept side: predict on input words, check result words
    always @(posedge i_clk) begin
        t_word   w;
        t_interp got, want;
        took = 1'b0;
        if (i_rst_n) begin
            idle_cycles++;
            if (in_ch.valid && in_ch.ready) begin
                took = 1'b1;
                idle_cycles = 0;
                w.is_query = in_ch.opcode;
                w.idx      = in_ch.record_index;
                w.tv       = in_ch.time_value;
                w.restart  = in_ch.restart_walk;
                if (w.is_query == OP_QUERY)
                    interp_q.push_back(interpolate(w));
                else
                    end_times[w.idx] = longint'(w.tv);
            end
            if (out_ch.valid && out_ch.ready) begin
                idle_cycles = 0;
                got.left_idx  = out_ch.left_index;
                got.right_idx = out_ch.right_index;
                got.wgt       = out_ch.weight;
                if (interp_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: result word with none expected: %0d %0d %0d",
                                 got.left_idx, got.right_idx, got.wgt);
                end else begin
                    want = interp_q.pop_front();
                    if (got.left_idx != want.left_idx || got.right_idx != want.right_idx
                            || got.wgt != want.wgt) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("ERROR: exp left %0d right %0d weight %0d, got %0d %0d %0d",
                                     want.left_idx, want.right_idx, want.wgt,
                                     got.left_idx, got.right_idx, got.wgt);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("time_table_interp_weights_test NOT OK");
                $finish;
            end
        end
    end

    // sender
    always @(negedge i_clk) begin
        t_word w;
        if (i_rst_n && (!in_ch.valid || took)) begin
            if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (word_q.size() != 0) begin
                w = word_q.pop_front();
                in_ch.valid        <= 1'b1;
                in_ch.opcode       <= w.is_query;
                in_ch.record_index <= w.idx;
                in_ch.time_value   <= w.tv;
                in_ch.restart_walk <= w.restart;
                send_gap = pick_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off when requested
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = 600;
                out_ch.ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                recv_stall = pick_gap();
            end
        end
    end

    task automatic push_load(int idx, longint t);
        t_word w;
        w.is_query = OP_LOAD;
        w.idx      = IDX_W'(idx);
        w.tv       = TIME_W'(t);
        w.restart  = 1'b0;
        word_q.push_back(w);
    endtask

    task automatic push_query(longint t, bit rs);
        t_word w;
        w.is_query = OP_QUERY;
        w.idx      = IDX_W'($urandom);
        w.tv       = TIME_W'(t);
        w.restart  = rs;
        word_q.push_back(w);
    endtask

    task automatic wait_idle();
        while (word_q.size() != 0 || in_ch.valid || interp_q.size() != 0)
            @(posedge i_clk);
        // loads leave no result; give the last one time to land
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = CFG_DATA_W'(val);
        if (idx == CFG_PERIOD)
            m_period = PER_W'(val);
        else if (idx == CFG_REFERENCE)
            m_reference = longint'(signed'(TIME_W'(val)));
        else if (idx == CFG_COUNT)
            m_count = CNT_W'(val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // increasing end times from lo toward hi over n entries
    task automatic build_table(int n, longint lo, longint hi);
        plan_n = n;
        plan_step = (hi - lo) / n;
        if (plan_step < 1)
            plan_step = 1;
        for (int i = 0; i < n; i++) begin
            plan[i] = lo + i * plan_step + rnd_below(plan_step);
            push_load(i, plan[i]);
        end
        cursor = plan[0];
    endtask

    function automatic longint pick_target();
        int r;
        r = $urandom_range(9);
        case (r)
            0: return plan[0] - 1 - rnd_below(4 * plan_step + 1);
            1: return plan[plan_n-1] + rnd_below(2 * plan_step + 1);
            2: return plan[$urandom_range(plan_n - 1)];
            default: begin
                cursor = cursor + rnd_below(plan_step + plan_step / 2 + 1);
                if (cursor > plan[plan_n-1])
                    cursor = plan[0] - rnd_below(plan_step + 1);
                return cursor;
            end
        endcase
    endfunction

    task automatic run_phase(longint unsigned per, longint refv, int cnt, int n_queries,
                             bit full_span);
        int     n, eff;
        longint lo, hi, t;
        wait_idle();
        write_reg(CFG_PERIOD, per);
        write_reg(CFG_REFERENCE, longint'(refv));
        write_reg(CFG_COUNT, cnt);
        eff = cnt == 0 ? 1 : (cnt > RECORD_DEPTH ? RECORD_DEPTH : cnt);
        n = eff < 2 ? 2 : eff;
        if (per > 1) begin
            lo = rnd_below(per / 8 + 1);
            hi = longint'(per);
        end else if (full_span) begin
            lo = -(64'sd1 <<< 61);
            hi = 64'sd1 <<< 61;
        end else begin
            lo = rnd_below(100000) - 50000;
            hi = lo + 1000 + rnd_below(100000);
        end
        build_table(n, lo, hi);
        // periodic tables sometimes end at one period or one below it
        if (per > 1 && $urandom_range(1)) begin
            plan[n-1] = longint'(per) - 1 + $urandom_range(1);
            push_load(n - 1, plan[n-1]);
        end
        for (int i = 0; i < n_queries; i++) begin
            if ($urandom_range(19) == 0) begin
                // out-of-order entry, may break monotonicity
                push_load($urandom_range(n - 1), plan[$urandom_range(n - 1)]
                          + rnd_below(3) - 1);
            end
            if (full_span && $urandom_range(3) == 0)
                t = longint'(rnd64());
            else begin
                t = pick_target();
                if (per > 1 && !full_span)
                    t = t + refv + longint'(per) * longint'(int'($urandom_range(4)) - 2);
            end
            push_query(t, $urandom_range(7) == 0);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        in_ch.valid        = 1'b0;
        in_ch.opcode       = OP_LOAD;
        in_ch.record_index = '0;
        in_ch.time_value   = '0;
        in_ch.restart_walk = 1'b0;
        out_ch.ready = 1'b0;
        n_errors = 0;
        send_gap = 0;
        recv_stall = 0;
        hold_cnt = 0;
        hold_req = 1'b0;
        quiet = 1'b0;
        took = 1'b0;
        idle_cycles = 0;
        walk_ptr = 0;
        last_request = 0;
        m_period = '0;
        m_reference = '0;
        m_count = 1;
        for (int i = 0; i < RECORD_DEPTH; i++)
            end_times[i] = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // every entry gets written before any query reads it
        for (int i = 0; i < RECORD_DEPTH; i++)
            push_load(i, i * 1000);
        wait_idle();
        write_reg(CFG_COUNT, RECORD_DEPTH);
        push_query(-(64'sd1 <<< 62), 1'b0);
        push_query((64'sd1 <<< 62) - 1, 1'b0);
        push_query(0, 1'b1);
        push_query(500, 1'b0);
        push_query(1000, 1'b0);
        push_query(62999, 1'b0);
        push_query(63000, 1'b0);
        push_query(1500, 1'b0);
        push_query(40250, 1'b1);
        push_load(5, 5000);
        push_load(6, 5000);
        push_query(5000, 1'b1);
        push_query(-1, 1'b0);

        // no idling, then the receiver holds off while queries keep coming
        quiet = 1'b1;
        run_phase(0, 0, 1, 10, 1'b0);
        wait_idle();
        quiet = 1'b0;
        run_phase(0, 0, RECORD_DEPTH, 25, 1'b0);
        hold_req = 1'b1;
        run_phase(1, -5, 8, 25, 1'b0);
        run_phase(0, 0, 0, 15, 1'b0);
        run_phase(86400 * 365, 12345, 12, 25, 1'b0);
        run_phase(1000, -777, RECORD_DEPTH, 25, 1'b0);
        run_phase(2, 0, 5, 20, 1'b0);
        run_phase((64'd1 << 62) - 1, -(64'sd1 <<< 62), 127, 25, 1'b1);
        run_phase(0, (64'sd1 <<< 62) - 1, 33, 25, 1'b1);
        run_phase(1000000, 999, 3, 20, 1'b0);

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && interp_q.size() == 0)
            $display("time_table_interp_weights_test OK");
        else
            $display("time_table_interp_weights_test NOT OK");
        $finish;
    end

endmodule
